// ===== hdl/sct_pkg.sv =====
// Package for the sensor count to temperature block: widths, codes, FSM states
// and the two calibration curves as constant functions.
// No dependencies.
`default_nettype none
package sct_pkg;

  localparam int STAGE_POINTS = 32;
  localparam int MOTOR_POINTS = 24;

  localparam int IDXW  = 5;   // table index
  localparam int XW    = 15;  // table abscissa
  localparam int DEGW  = 9;   // table temperature, signed whole degrees
  localparam int NUMW  = 28;  // abscissa numerator
  localparam int DENW  = 16;  // abscissa denominator
  localparam int PRODW = XW + DENW;
  localparam int DW    = 24;  // segment width times denominator
  localparam int DTW   = 4;   // temperature step of one segment
  localparam int NW    = DTW + DW;
  localparam int QW    = 13;  // interpolated fraction, Q8
  localparam int DIVNW = NW + 9;
  localparam int DVSW  = DW + 1;
  localparam int TEMPW = 17;
  localparam int CNTW  = 4;

  localparam logic [IDXW-1:0] STAGE_LAST = IDXW'(STAGE_POINTS - 1);
  localparam logic [IDXW-1:0] MOTOR_LAST = IDXW'(MOTOR_POINTS - 1);
  localparam logic [12:0]     SERIES_OHM = 13'd4700;
  localparam logic [16:0]     FULL_SCALE = 17'd32768;

  localparam logic SEL_STAGE = 1'b0;
  localparam logic SEL_MOTOR = 1'b1;

  localparam logic [1:0] ST_INTERP = 2'd0;
  localparam logic [1:0] ST_LOW    = 2'd1;
  localparam logic [1:0] ST_HIGH   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_SCAN,
    S_MUL,
    S_START,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [XW-1:0]          x;
    logic signed [DEGW-1:0] deg;
  } curve_pt_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic curve_pt_t mk_pt(input int x, input int deg);
    curve_pt_t p;
    p.x   = XW'(x);
    p.deg = DEGW'(deg);
    return p;
  endfunction

  function automatic curve_pt_t stage_pt(input logic [IDXW-1:0] i);
    curve_pt_t p;
    case (i)
      5'd0:    p = mk_pt(16308, -30);
      5'd1:    p = mk_pt(16387, -25);
      5'd2:    p = mk_pt(16487, -20);
      5'd3:    p = mk_pt(16609, -15);
      5'd4:    p = mk_pt(16757, -10);
      5'd5:    p = mk_pt(16938,  -5);
      5'd6:    p = mk_pt(17151,   0);
      5'd7:    p = mk_pt(17400,   5);
      5'd8:    p = mk_pt(17688,  10);
      5'd9:    p = mk_pt(18017,  15);
      5'd10:   p = mk_pt(18387,  20);
      5'd11:   p = mk_pt(18797,  25);
      5'd12:   p = mk_pt(19247,  30);
      5'd13:   p = mk_pt(19733,  35);
      5'd14:   p = mk_pt(20250,  40);
      5'd15:   p = mk_pt(20793,  45);
      5'd16:   p = mk_pt(21357,  50);
      5'd17:   p = mk_pt(21933,  55);
      5'd18:   p = mk_pt(22515,  60);
      5'd19:   p = mk_pt(23097,  65);
      5'd20:   p = mk_pt(23671,  70);
      5'd21:   p = mk_pt(24232,  75);
      5'd22:   p = mk_pt(24775,  80);
      5'd23:   p = mk_pt(25296,  85);
      5'd24:   p = mk_pt(25792,  90);
      5'd25:   p = mk_pt(26261,  95);
      5'd26:   p = mk_pt(26702, 100);
      5'd27:   p = mk_pt(27114, 105);
      5'd28:   p = mk_pt(27497, 110);
      5'd29:   p = mk_pt(27851, 115);
      5'd30:   p = mk_pt(28179, 120);
      default: p = mk_pt(28480, 125);
    endcase
    return p;
  endfunction

  function automatic curve_pt_t motor_pt(input logic [IDXW-1:0] i);
    curve_pt_t p;
    case (i)
      5'd0:    p = mk_pt( 980, -55);
      5'd1:    p = mk_pt(1030, -50);
      5'd2:    p = mk_pt(1135, -40);
      5'd3:    p = mk_pt(1247, -30);
      5'd4:    p = mk_pt(1367, -20);
      5'd5:    p = mk_pt(1495, -10);
      5'd6:    p = mk_pt(1630,   0);
      5'd7:    p = mk_pt(1772,  10);
      5'd8:    p = mk_pt(1922,  20);
      5'd9:    p = mk_pt(2000,  25);
      5'd10:   p = mk_pt(2080,  30);
      5'd11:   p = mk_pt(2245,  40);
      5'd12:   p = mk_pt(2417,  50);
      5'd13:   p = mk_pt(2597,  60);
      5'd14:   p = mk_pt(2785,  70);
      5'd15:   p = mk_pt(2980,  80);
      5'd16:   p = mk_pt(3182,  90);
      5'd17:   p = mk_pt(3392, 100);
      5'd18:   p = mk_pt(3607, 110);
      5'd19:   p = mk_pt(3817, 120);
      5'd20:   p = mk_pt(3915, 125);
      5'd21:   p = mk_pt(4008, 130);
      5'd22:   p = mk_pt(4166, 140);
      default: p = mk_pt(4280, 150);
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/sct_rom.sv =====
// Synchronous calibration table memory, one read port, registered output.
// Depends on sct_pkg for the curve contents and entry type.
`default_nettype none
module sct_rom
  import sct_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            sel,
  input  wire logic [IDXW-1:0] addr,
  output curve_pt_t            pt_r
);

  always_ff @(posedge clk) begin
    if (sel == SEL_MOTOR) begin
      pt_r <= motor_pt(addr);
    end else begin
      pt_r <= stage_pt(addr);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sct_div.sv =====
// Restoring divider, one quotient bit per cycle, QW quotient bits per division.
// Depends on sct_pkg for widths and the status struct.
`default_nettype none
module sct_div
  import sct_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIVNW-1:0] dividend,
  input  wire logic [DVSW-1:0]  divisor,
  output logic      [QW-1:0]    quotient,
  output div_stat_t             stat
);

  logic [DIVNW-1:0] rem_r, rem_nxt;
  logic [DIVNW-1:0] dvs_r, dvs_nxt;
  logic [QW-1:0]    quo_r, quo_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  always_comb begin
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = dividend;
      dvs_nxt  = DIVNW'({divisor, {(QW-1){1'b0}}});
      cnt_nxt  = CNTW'(QW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= dvs_r) begin
        rem_nxt = rem_r - dvs_r;
        quo_nxt = {quo_r[QW-2:0], 1'b1};
      end else begin
        quo_nxt = {quo_r[QW-2:0], 1'b0};
      end
      dvs_nxt = dvs_r >> 1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

// ===== hdl/sensor_count_to_temperature.sv =====
// Raw count to temperature by piecewise linear interpolation over a table in memory.
// Motor counts of 32768 and up are clamped without a table scan; other counts are
//   scanned to a clamp or to segment k (at most 31), which the divider then interpolates.
// Throughput: one transaction at a time; the table scan (one entry per memory read) and
//   the 13-step divider set the figure. A new input is taken once the result is registered.
// Reset: synchronous active-low rst_n clears the sequencer, divider and output valid.
// Depends on sct_pkg, sct_rom and sct_div.
`default_nettype none
module sensor_count_to_temperature
  import sct_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] raw_count
  input  wire logic        in_tuser,   // [0] action (curve select)
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,  // [16:0] temperature_q8, [23:17] zero
  output logic      [1:0]  out_tuser   // [1:0] clamp_status
);

  // Sequencer state
  state_t state_r, state_nxt;

  // Abscissa num/den, curve select, scan position
  logic                   sel_r, sel_nxt;
  logic [NUMW-1:0]        num_r, num_nxt;
  logic [DENW-1:0]        den_r, den_nxt;
  logic [IDXW-1:0]        idx_r, idx_nxt;   // address presented to the table
  logic [IDXW-1:0]        k_r, k_nxt;       // index of the entry now at the table output
  logic [PRODW-1:0]       p_prev_r, p_prev_nxt;
  logic signed [DEGW-1:0] prev_deg_r, prev_deg_nxt;

  // Interpolation operands
  logic [DW-1:0]          d_r, d_nxt;
  logic [DW-1:0]          r_r, r_nxt;
  logic [DTW-1:0]         dt_r, dt_nxt;
  logic [NW-1:0]          n_r, n_nxt;

  // Result holding and output register
  logic [TEMPW-1:0]       res_temp_r, res_temp_nxt;
  logic [1:0]             res_st_r, res_st_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [TEMPW-1:0]       out_temp_r, out_temp_nxt;
  logic [1:0]             out_st_r, out_st_nxt;

  // Table memory and divider
  curve_pt_t              pt;
  logic                   div_start;
  logic [DIVNW-1:0]       div_dividend;
  logic [DVSW-1:0]        div_divisor;
  logic [QW-1:0]          div_quo;
  div_stat_t              div_stat;

  // Scan datapath: current entry times the denominator
  logic [PRODW-1:0]       p;
  logic [PRODW-1:0]       num_ext;
  logic                   hit;
  logic [IDXW-1:0]        last_k;
  logic [28:0]            motor_num;
  logic [16:0]            motor_den;
  logic signed [DEGW-1:0] deg_step;
  logic                   in_acc;

  localparam curve_pt_t STAGE_LO_PT = stage_pt('0);
  localparam curve_pt_t MOTOR_LO_PT = motor_pt('0);
  localparam curve_pt_t STAGE_HI_PT = stage_pt(STAGE_LAST);
  localparam curve_pt_t MOTOR_HI_PT = motor_pt(MOTOR_LAST);

  localparam logic [TEMPW-1:0] STAGE_LO_Q8 = {STAGE_LO_PT.deg, 8'h00};
  localparam logic [TEMPW-1:0] MOTOR_LO_Q8 = {MOTOR_LO_PT.deg, 8'h00};
  localparam logic [TEMPW-1:0] STAGE_HI_Q8 = {STAGE_HI_PT.deg, 8'h00};
  localparam logic [TEMPW-1:0] MOTOR_HI_Q8 = {MOTOR_HI_PT.deg, 8'h00};

  sct_rom u_rom (
    .clk  (clk),
    .sel  (sel_r),
    .addr (idx_r),
    .pt_r (pt)
  );

  sct_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign p         = PRODW'(pt.x) * PRODW'(den_r);
  assign num_ext   = PRODW'(num_r);
  assign hit       = (num_ext <= p);
  assign last_k    = (sel_r == SEL_MOTOR) ? MOTOR_LAST : STAGE_LAST;
  assign motor_num = 29'(SERIES_OHM) * 29'(in_tdata);
  assign motor_den = FULL_SCALE - {1'b0, in_tdata};
  assign deg_step  = pt.deg - prev_deg_r;

  // Rounded fraction: floor((2n + d) / 2d), n = 256 * dt * r
  assign div_dividend = {n_r, 9'd0} + DIVNW'(d_r);
  assign div_divisor  = {d_r, 1'b0};

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    p_prev_nxt    = p_prev_r;
    prev_deg_nxt  = prev_deg_r;
    d_nxt         = d_r;
    r_nxt         = r_r;
    dt_nxt        = dt_r;
    n_nxt         = n_r;
    res_temp_nxt  = res_temp_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r;
    out_temp_nxt  = out_temp_r;
    out_st_nxt    = out_st_r;
    div_start     = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          sel_nxt = in_tuser;
          idx_nxt = '0;
          k_nxt   = '0;
          if (in_tuser == SEL_STAGE) begin
            num_nxt   = NUMW'(in_tdata);
            den_nxt   = DENW'(1);
            state_nxt = S_FETCH;
          end else if ({1'b0, in_tdata} == FULL_SCALE) begin
            // infinite resistance
            res_temp_nxt = MOTOR_HI_Q8;
            res_st_nxt   = ST_HIGH;
            state_nxt    = S_DONE;
          end else if ({1'b0, in_tdata} > FULL_SCALE) begin
            // negative resistance
            res_temp_nxt = MOTOR_LO_Q8;
            res_st_nxt   = ST_LOW;
            state_nxt    = S_DONE;
          end else begin
            num_nxt   = motor_num[NUMW-1:0];
            den_nxt   = motor_den[DENW-1:0];
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        idx_nxt      = idx_r + 1'b1;
        k_nxt        = k_r + 1'b1;
        p_prev_nxt   = p;
        prev_deg_nxt = pt.deg;
        d_nxt        = DW'(p - p_prev_r);
        r_nxt        = DW'(num_ext - p_prev_r);
        dt_nxt       = deg_step[DTW-1:0];
        if (k_r == '0) begin
          if (hit) begin
            res_temp_nxt = {pt.deg, 8'h00};
            res_st_nxt   = ST_LOW;
            state_nxt    = S_DONE;
          end
        end else if (k_r == last_k) begin
          // at the last entry equality counts as a high clamp
          if (num_ext < p) begin
            p_prev_nxt   = p_prev_r;
            prev_deg_nxt = prev_deg_r;
            state_nxt    = S_MUL;
          end else begin
            res_temp_nxt = {pt.deg, 8'h00};
            res_st_nxt   = ST_HIGH;
            state_nxt    = S_DONE;
          end
        end else if (hit) begin
          p_prev_nxt   = p_prev_r;
          prev_deg_nxt = prev_deg_r;
          state_nxt    = S_MUL;
        end
      end
      S_MUL: begin
        n_nxt     = NW'(dt_r) * NW'(r_r);
        state_nxt = S_START;
      end
      S_START: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          res_temp_nxt = {prev_deg_r, 8'h00} + TEMPW'(div_quo);
          res_st_nxt   = ST_INTERP;
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_temp_nxt  = res_temp_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r      <= sel_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    idx_r      <= idx_nxt;
    k_r        <= k_nxt;
    p_prev_r   <= p_prev_nxt;
    prev_deg_r <= prev_deg_nxt;
    d_r        <= d_nxt;
    r_r        <= r_nxt;
    dt_r       <= dt_nxt;
    n_r        <= n_nxt;
    res_temp_r <= res_temp_nxt;
    res_st_r   <= res_st_nxt;
    out_temp_r <= out_temp_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_temp_r};
  assign out_tuser  = out_st_r;

  // A low clamp always reports one of the two low-end temperatures
  a_low_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_LOW |->
      out_tdata[16:0] == STAGE_LO_Q8 || out_tdata[16:0] == MOTOR_LO_Q8)
    else $error("low clamp with wrong temperature");

  // A high clamp always reports one of the two high-end temperatures
  a_high_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_HIGH |->
      out_tdata[16:0] == STAGE_HI_Q8 || out_tdata[16:0] == MOTOR_HI_Q8)
    else $error("high clamp with wrong temperature");

  // Divider completion only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == S_DIV)
    else $error("divider finished outside the wait state");

  // The scan never runs past the end of the selected curve
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> k_r <= last_k)
    else $error("table scan past last entry");

endmodule
`default_nettype wire

// ===== tb/temperature_checker.sv =====
// Scoreboard for sensor_count_to_temperature: watches both stream channels and predicts
// each temperature from the two calibration curves using exact integer arithmetic.
// Depends on sct_pkg for codes and sizes.
module temperature_checker
  import sct_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        sel;
    logic [15:0] raw;
    logic [16:0] q8;
    logic [1:0]  clamp;
  } reading_t;

  // calibration points: abscissa and whole degrees
  int stage_x [STAGE_POINTS] = '{
    16308, 16387, 16487, 16609, 16757, 16938, 17151, 17400, 17688, 18017,
    18387, 18797, 19247, 19733, 20250, 20793, 21357, 21933, 22515, 23097,
    23671, 24232, 24775, 25296, 25792, 26261, 26702, 27114, 27497, 27851,
    28179, 28480};
  int stage_deg [STAGE_POINTS] = '{
    -30, -25, -20, -15, -10, -5, 0, 5, 10, 15, 20, 25, 30, 35, 40, 45,
    50, 55, 60, 65, 70, 75, 80, 85, 90, 95, 100, 105, 110, 115, 120, 125};
  int motor_x [MOTOR_POINTS] = '{
    980, 1030, 1135, 1247, 1367, 1495, 1630, 1772, 1922, 2000, 2080, 2245,
    2417, 2597, 2785, 2980, 3182, 3392, 3607, 3817, 3915, 4008, 4166, 4280};
  int motor_deg [MOTOR_POINTS] = '{
    -55, -50, -40, -30, -20, -10, 0, 10, 20, 25, 30, 40,
    50, 60, 70, 80, 90, 100, 110, 120, 125, 130, 140, 150};

  reading_t pending_readings [$];
  int       fail_count = 0;

  function automatic longint x_at(input logic motor, input int i);
    return motor ? longint'(motor_x[i]) : longint'(stage_x[i]);
  endfunction

  function automatic longint deg_at(input logic motor, input int i);
    return motor ? longint'(motor_deg[i]) : longint'(stage_deg[i]);
  endfunction

  // floor division, b > 0
  function automatic longint floor_div(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  // abscissa is num/den with den > 0
  function automatic reading_t curve_lookup(input logic motor, input longint num,
                                            input longint den);
    reading_t r;
    int       last;
    int       i;
    longint   x0, x1, d0, d1, n, d;
    r      = '0;
    last   = motor ? MOTOR_POINTS - 1 : STAGE_POINTS - 1;
    r.clamp = ST_HIGH;
    r.q8    = 17'(deg_at(motor, last) * 256);
    if (num <= x_at(motor, 0) * den) begin
      r.clamp = ST_LOW;
      r.q8    = 17'(deg_at(motor, 0) * 256);
      return r;
    end
    if (num >= x_at(motor, last) * den) return r;
    for (i = 1; i <= last; i++) begin
      x1 = x_at(motor, i);
      if (num <= x1 * den) begin
        x0 = x_at(motor, i - 1);
        d0 = deg_at(motor, i - 1);
        d1 = deg_at(motor, i);
        r.clamp = ST_INTERP;
        if (x1 <= x0) begin
          r.q8 = 17'(d1 * 256);
        end else begin
          n    = 256 * (d1 - d0) * (num - x0 * den);
          d    = den * (x1 - x0);
          // round half up
          r.q8 = 17'(d0 * 256 + floor_div(2 * n + d, 2 * d));
        end
        return r;
      end
    end
    return r;
  endfunction

  function automatic reading_t temperature_of(input logic sel, input logic [15:0] raw);
    reading_t r;
    longint   count;
    count = longint'(raw);
    if (sel == SEL_STAGE) begin
      r = curve_lookup(1'b0, count, 1);
    end else if (count == longint'(FULL_SCALE)) begin
      // infinite resistance
      r       = '0;
      r.clamp = ST_HIGH;
      r.q8    = 17'(deg_at(1'b1, MOTOR_POINTS - 1) * 256);
    end else if (count > longint'(FULL_SCALE)) begin
      // negative resistance
      r       = '0;
      r.clamp = ST_LOW;
      r.q8    = 17'(deg_at(1'b1, 0) * 256);
    end else begin
      r = curve_lookup(1'b1, longint'(SERIES_OHM) * count, longint'(FULL_SCALE) - count);
    end
    r.sel = sel;
    r.raw = raw;
    return r;
  endfunction

  task automatic report(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    reading_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_readings.size() == 0) begin
          report($sformatf("result transaction with nothing expected, data %h status %0d",
                           out_tdata, out_tuser));
        end else begin
          want = pending_readings.pop_front();
          if (out_tdata[16:0] !== want.q8)
            report($sformatf("temperature %0d, want %0d (curve %0d, count %0d)",
                             $signed(out_tdata[16:0]), $signed(want.q8), want.sel, want.raw));
          if (out_tdata[23:17] !== 7'd0)
            report($sformatf("pad bits %h not zero (curve %0d, count %0d)",
                             out_tdata[23:17], want.sel, want.raw));
          if (out_tuser !== want.clamp)
            report($sformatf("clamp status %0d, want %0d (curve %0d, count %0d)",
                             out_tuser, want.clamp, want.sel, want.raw));
        end
      end
      if (in_tvalid && in_tready)
        pending_readings.push_back(temperature_of(in_tuser, in_tdata));
    end
    outstanding <= pending_readings.size();
    mismatches  <= fail_count;
  end

endmodule

// ===== tb/sensor_count_to_temperature_tb.sv =====
// Top of the sensor_count_to_temperature testbench: clock, reset, stimulus and verdict.
// Depends on sct_pkg, the block's RTL and temperature_checker.
module sensor_count_to_temperature_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sct_pkg::*;

  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int STALL_LIMIT   = 2000;  // cycles with no transaction before giving up
  localparam int SETTLE_CYCLES = 60;    // margin over the worst latency

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;    // [15:0] raw_count
  logic        in_tuser   = 1'b0;  // [0] action (curve select)
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;          // [16:0] temperature_q8, [23:17] zero
  logic [1:0]  out_tuser;          // [1:0] clamp_status

  int   mismatches;
  int   outstanding;
  int   idle_cycles = 0;
  logic quiet       = 1'b0;  // no idling on either side when set
  logic hold_req    = 1'b0;  // asks the receiver for one long hold-off

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sensor_count_to_temperature dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  temperature_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Offer one reading and hold it until the transaction completes. Valid stays high
  // into the next call unless a random gap is inserted here, so it is never lowered
  // and raised in the same step.
  task automatic offer_reading(input logic sel, input logic [15:0] raw);
    in_tvalid <= 1'b1;
    in_tuser  <= sel;
    in_tdata  <= raw;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Mostly counts that land inside a table, the rest around motor full scale or anywhere.
  task automatic random_readings(input int count);
    logic        sel;
    logic [15:0] raw;
    repeat (count) begin
      sel = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5:
          raw = (sel == SEL_MOTOR) ? 16'($urandom_range(5500, 15800))
                                   : 16'($urandom_range(16200, 28600));
        6:       raw = 16'($urandom_range(32760, 32776));
        default: raw = 16'($urandom);
      endcase
      offer_reading(sel, raw);
    end
  endtask

  // Drop valid and wait until every expected result has come back. The first edge
  // lets the checker count a transaction accepted in the current step.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Receiver: random ready bursts, one long hold-off on request, always ready when quiet.
  initial begin : receiver
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: any transaction on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    // table ends, their neighbors, an exact interior point, upper count bits
    int     stage_edges [10] = '{0, 16307, 16308, 16309, 17151, 22000,
                                 28479, 28480, 28481, 65535};
    // zero, motor table ends, mid table, full scale and beyond
    int     motor_edges [13] = '{0, 1, 5653, 5654, 5655, 10000, 15617, 15618,
                                 15619, 32767, 32768, 32769, 65535};
    int     tie_counts [$];
    int     raw, i;
    longint s, num, x0, x1, dt, n2, d;
    curve_pt_t p0, p1;

    // Look for motor counts whose interpolated value lands exactly on half an LSB,
    // so the round-half-up path gets exercised.
    for (raw = 5600; raw < 15700 && tie_counts.size() < 2; raw++) begin
      s   = 32768 - raw;
      num = 4700 * longint'(raw);
      for (i = 1; i < MOTOR_POINTS; i++) begin
        p0 = motor_pt(IDXW'(i - 1));
        p1 = motor_pt(IDXW'(i));
        x0 = longint'(p0.x);
        x1 = longint'(p1.x);
        if (num > x0 * s && num < x1 * s) begin
          dt = longint'($signed(p1.deg)) - longint'($signed(p0.deg));
          d  = s * (x1 - x0);
          n2 = 512 * dt * (num - x0 * s);
          if ((n2 + d) % (2 * d) == 0) tie_counts.push_back(raw);
        end
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    foreach (stage_edges[k]) offer_reading(SEL_STAGE, 16'(stage_edges[k]));
    foreach (motor_edges[k]) offer_reading(SEL_MOTOR, 16'(motor_edges[k]));
    foreach (tie_counts[k])  offer_reading(SEL_MOTOR, 16'(tie_counts[k]));

    random_readings(330);

    // Receiver holds off for a long stretch while readings keep coming, so the
    // block backs up and stalls its input.
    hold_req = 1'b1;
    random_readings(20);

    // Sender pause until the pipeline is empty.
    drain_results();

    random_readings(300);

    // Final stretch with both sides always ready.
    quiet = 1'b1;
    random_readings(150);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
